FILE: hdl/c8alu_pkg.sv
// Package for the 8-bit ALU and load execute block: register file and flag
// types, opcode field codes and the register slot helper. No dependencies.
package c8alu_pkg;

    localparam int unsigned NUM_REGS = 7;

    typedef logic [NUM_REGS-1:0][7:0] t_regfile;

    typedef struct packed {
        logic s;
        logic z;
        logic h;
        logic pv;
        logic n;
        logic c;
    } t_flags;

    // Memory side effect of one instruction
    typedef struct packed {
        logic       wr;
        logic [7:0] data;
    } t_mem_req;

    // Instruction classes (bits 7:6)
    localparam logic [1:0] CLS_MISC   = 2'b00;
    localparam logic [1:0] CLS_LOAD   = 2'b01;
    localparam logic [1:0] CLS_ALU    = 2'b10;
    localparam logic [1:0] CLS_UNUSED = 2'b11;

    // ALU operations (bits 5:3 of class ALU)
    localparam logic [2:0] ALU_ADD = 3'd0;
    localparam logic [2:0] ALU_SUB = 3'd2;
    localparam logic [2:0] ALU_AND = 3'd4;
    localparam logic [2:0] ALU_XOR = 3'd5;
    localparam logic [2:0] ALU_OR  = 3'd6;
    localparam logic [2:0] ALU_CP  = 3'd7;

    // Low field codes of class MISC
    localparam logic [2:0] MISC_INC = 3'd4;
    localparam logic [2:0] MISC_DEC = 3'd5;
    localparam logic [2:0] MISC_LDI = 3'd6;

    // Operand indexes and register slots
    localparam logic [2:0] IDX_MEM = 3'd6;
    localparam logic [2:0] IDX_A   = 3'd7;
    localparam logic [2:0] SLOT_A  = 3'd6;
    localparam logic [2:0] SLOT_H  = 3'd4;
    localparam logic [2:0] SLOT_L  = 3'd5;

    // Operand index to register file slot; A lives in the slot (HL) leaves free
    function automatic logic [2:0] slot_of(input logic [2:0] idx);
        slot_of = (idx == IDX_A) ? SLOT_A : idx;
    endfunction

endpackage

FILE: hdl/c8alu_exec.sv
// Combinational execute unit: decodes one instruction byte and works out the
// next register file, flags, halt request and memory write. Uses c8alu_pkg.
module c8alu_exec (
    input  logic [7:0]         i_opcode,
    input  logic [7:0]         i_immediate,
    input  logic [7:0]         i_mem_data,
    input  c8alu_pkg::t_regfile i_regs,
    input  c8alu_pkg::t_flags   i_flags,
    output c8alu_pkg::t_regfile o_regs,
    output c8alu_pkg::t_flags   o_flags,
    output logic               o_halt_set,
    output c8alu_pkg::t_mem_req o_mem
);
    import c8alu_pkg::*;

    logic [1:0] cls;
    logic [2:0] fy;
    logic [2:0] fz;
    logic [7:0] acc;
    logic [7:0] src;
    logic [7:0] dst_old;
    logic [8:0] sum;
    logic [4:0] hsum;
    logic [8:0] dif;
    logic [4:0] hdif;
    logic [7:0] inc_v;
    logic [7:0] dec_v;
    logic [7:0] logic_v;
    logic       wr_en;
    logic [2:0] wr_idx;
    logic [7:0] wr_val;

    assign cls     = i_opcode[7:6];
    assign fy      = i_opcode[5:3];
    assign fz      = i_opcode[2:0];
    assign acc     = i_regs[SLOT_A];
    assign src     = (fz == IDX_MEM) ? i_mem_data : i_regs[slot_of(fz)];
    assign dst_old = (fy == IDX_MEM) ? i_mem_data : i_regs[slot_of(fy)];
    assign sum     = {1'b0, acc} + {1'b0, src};
    assign hsum    = {1'b0, acc[3:0]} + {1'b0, src[3:0]};
    assign dif     = {1'b0, acc} - {1'b0, src};
    assign hdif    = {1'b0, acc[3:0]} - {1'b0, src[3:0]};
    assign inc_v   = dst_old + 8'd1;
    assign dec_v   = dst_old - 8'd1;

    always_comb begin
        o_regs     = i_regs;
        o_flags    = i_flags;
        o_halt_set = 1'b0;
        wr_en      = 1'b0;
        wr_idx     = fy;
        wr_val     = src;
        logic_v    = 8'd0;
        o_mem      = '0;

        unique case (cls)
            CLS_ALU: begin
                unique case (fy)
                    ALU_ADD: begin
                        o_regs[SLOT_A] = sum[7:0];
                        o_flags.s  = sum[7];
                        o_flags.z  = (sum[7:0] == 8'd0);
                        o_flags.h  = hsum[4];
                        o_flags.pv = (acc[7] == src[7]) && (sum[7] != acc[7]);
                        o_flags.n  = 1'b0;
                        o_flags.c  = sum[8];
                    end
                    ALU_SUB, ALU_CP: begin
                        if (fy == ALU_SUB) begin
                            o_regs[SLOT_A] = dif[7:0];
                        end
                        o_flags.s  = dif[7];
                        o_flags.z  = (dif[7:0] == 8'd0);
                        o_flags.h  = hdif[4];
                        o_flags.pv = (acc[7] != src[7]) && (dif[7] != acc[7]);
                        o_flags.n  = 1'b1;
                        o_flags.c  = dif[8];
                    end
                    ALU_AND, ALU_XOR, ALU_OR: begin
                        if (fy == ALU_AND) begin
                            logic_v = acc & src;
                        end else if (fy == ALU_XOR) begin
                            logic_v = acc ^ src;
                        end else begin
                            logic_v = acc | src;
                        end
                        o_regs[SLOT_A] = logic_v;
                        o_flags.s  = logic_v[7];
                        o_flags.z  = (logic_v == 8'd0);
                        o_flags.h  = (fy == ALU_AND);
                        o_flags.pv = ~^logic_v;
                        o_flags.n  = 1'b0;
                        o_flags.c  = 1'b0;
                    end
                    default: ; // ADC and SBC: no effect
                endcase
            end
            CLS_LOAD: begin
                if ((fy == IDX_MEM) && (fz == IDX_MEM)) begin
                    o_halt_set = 1'b1;
                end else begin
                    wr_en  = 1'b1;
                    wr_val = src;
                end
            end
            CLS_MISC: begin
                if (fz == MISC_LDI) begin
                    wr_en  = 1'b1;
                    wr_val = i_immediate;
                end else if (fz == MISC_INC) begin
                    wr_en      = 1'b1;
                    wr_val     = inc_v;
                    o_flags.s  = inc_v[7];
                    o_flags.z  = (inc_v == 8'd0);
                    o_flags.h  = (dst_old[3:0] == 4'hF);
                    o_flags.pv = (dst_old == 8'h7F);
                    o_flags.n  = 1'b0;
                end else if (fz == MISC_DEC) begin
                    wr_en      = 1'b1;
                    wr_val     = dec_v;
                    o_flags.s  = dec_v[7];
                    o_flags.z  = (dec_v == 8'd0);
                    o_flags.h  = (dst_old[3:0] == 4'h0);
                    o_flags.pv = (dst_old == 8'h80);
                    o_flags.n  = 1'b1;
                end
            end
            CLS_UNUSED: ;
            default: ;
        endcase

        // Write-back: index (HL) becomes a memory write request
        if (wr_en) begin
            if (wr_idx == IDX_MEM) begin
                o_mem.wr   = 1'b1;
                o_mem.data = wr_val;
            end else begin
                o_regs[slot_of(wr_idx)] = wr_val;
            end
        end
    end

endmodule

FILE: hdl/cpu8_alu_and_load_execute_top.sv
// Top level of the 8-bit ALU and load execute block.
// Depends on c8alu_pkg and c8alu_exec.
//
// Executes one instruction byte per request against an internal register file
// B, C, D, E, H, L, A and the flags S Z H P/V N C. Requests enter an input
// register; the execute stage reads that register together with the register
// file, runs the ALU, flag logic and write-back and loads the result register.
// One request is taken every cycle while the consumer does not stall. Both sides
// use valid/ready; while the result register is held by a stalled consumer, one
// further request can wait in the input register. Register and flag updates
// happen as a request passes from the input register to the result register,
// so each request sees the state left by the previous one. A write to (HL) is
// returned as a memory write request with address HL as it stood before the
// instruction; with no write, address and data read zero. HALT only sets a
// sticky status bit that reset alone clears. Unimplemented opcodes change
// nothing.
module cpu8_alu_and_load_execute_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_opcode,
    input  logic [7:0]  i_immediate,
    input  logic [7:0]  i_memory_read_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_mem_write,
    output logic [15:0] o_mem_address,
    output logic [7:0]  o_mem_write_data,
    output logic [7:0]  o_accumulator,
    output logic        o_sign_flag,
    output logic        o_zero_flag,
    output logic        o_half_carry_flag,
    output logic        o_parity_overflow_flag,
    output logic        o_subtract_flag,
    output logic        o_carry_flag,
    output logic        o_halted
);
    import c8alu_pkg::*;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_opcode;
    logic [7:0] r_immediate;
    logic [7:0] r_mem_data;

    // Architectural state
    t_regfile r_regs;
    t_flags   r_flags;
    logic     r_halt;

    // Result register
    logic        r_out_valid;
    logic        r_mem_write;
    logic [15:0] r_mem_address;
    logic [7:0]  r_mem_write_data;
    logic [7:0]  r_accumulator;
    t_flags      r_out_flags;
    logic        r_halted;

    // Execute stage outputs
    t_regfile n_regs;
    t_flags   n_flags;
    logic     n_halt_set;
    t_mem_req n_mem;
    logic     n_halt;

    logic advance;
    logic take_in;

    // Execute when the result register is empty or being drained this cycle
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign take_in    = i_in_valid && o_in_ready;
    assign n_halt     = r_halt | n_halt_set;

    c8alu_exec u_exec (
        .i_opcode    (r_opcode),
        .i_immediate (r_immediate),
        .i_mem_data  (r_mem_data),
        .i_regs      (r_regs),
        .i_flags     (r_flags),
        .o_regs      (n_regs),
        .o_flags     (n_flags),
        .o_halt_set  (n_halt_set),
        .o_mem       (n_mem)
    );

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_regs      <= '0;
            r_flags     <= '0;
            r_halt      <= 1'b0;
        end else begin
            if (take_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
                r_regs      <= n_regs;
                r_flags     <= n_flags;
                r_halt      <= n_halt;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_opcode    <= i_opcode;
            r_immediate <= i_immediate;
            r_mem_data  <= i_memory_read_data;
        end
        if (advance) begin
            r_mem_write      <= n_mem.wr;
            r_mem_address    <= n_mem.wr ? {r_regs[SLOT_H], r_regs[SLOT_L]} : 16'd0;
            r_mem_write_data <= n_mem.data;
            r_accumulator    <= n_regs[SLOT_A];
            r_out_flags      <= n_flags;
            r_halted         <= n_halt;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_mem_write            = r_mem_write;
    assign o_mem_address          = r_mem_address;
    assign o_mem_write_data       = r_mem_write_data;
    assign o_accumulator          = r_accumulator;
    assign o_sign_flag            = r_out_flags.s;
    assign o_zero_flag            = r_out_flags.z;
    assign o_half_carry_flag      = r_out_flags.h;
    assign o_parity_overflow_flag = r_out_flags.pv;
    assign o_subtract_flag        = r_out_flags.n;
    assign o_carry_flag           = r_out_flags.c;
    assign o_halted               = r_halted;

endmodule

FILE: hdl/c8alu_checker.sv
// Port-level checker for cpu8_alu_and_load_execute_top, bound to every instance.
// No package dependency.
module c8alu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_mem_write,
    input logic [15:0] o_mem_address,
    input logic [7:0]  o_mem_write_data,
    input logic [7:0]  o_accumulator,
    input logic        o_halted
);

    // A stalled result keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_accumulator) && $stable(o_mem_address)))
        else $error("stalled result changed");

    // Without a write request, address and data read zero
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_mem_write) |->
            (o_mem_address == 16'd0 && o_mem_write_data == 8'd0))
        else $error("address or data set without a write request");

    // Halt status is sticky across results
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_halted) |=> (!o_out_valid || o_halted))
        else $error("halt status cleared");

    // Every result shown is taken before it vanishes
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped without acceptance");

endmodule

bind cpu8_alu_and_load_execute_top c8alu_checker u_c8alu_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_mem_write      (o_mem_write),
    .o_mem_address    (o_mem_address),
    .o_mem_write_data (o_mem_write_data),
    .o_accumulator    (o_accumulator),
    .o_halted         (o_halted)
);
